// ----- sv/albm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albm_pkg
// Shared widths, register indexes and saturating helpers of the level meter.
// ----------------------------------------------------------------------------
package albm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int IDX_BITS    = 8;
    localparam int DATA_BITS   = 16;

    localparam logic [IDX_BITS-1:0] REG_SPLIT_COEF = 8'd0;
    localparam logic [IDX_BITS-1:0] REG_WIN_LEN    = 8'd1;

    localparam logic [15:0] SPLIT_COEF_RST = 16'd59022;
    localparam logic [15:0] WIN_LEN_RST    = 16'd2400;

    // 100*log10(2) in Q16
    localparam logic [31:0] DB_SCALE = 32'd1972830;
    localparam logic [10:0] DB_LIMIT = 11'd1500;

    typedef logic signed [11:0] t_db;

    // Bit 56 of the result flags saturation.
    function automatic logic [56:0] sat_add56(input logic [55:0] acc, input logic [55:0] v);
        logic [56:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[56] ? {1'b1, {56{1'b1}}} : s;
    endfunction

    // Bit 48 of the result flags saturation.
    function automatic logic [48:0] sat_add48(input logic [47:0] acc, input logic [47:0] v);
        logic [48:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[48] ? {1'b1, {48{1'b1}}} : s;
    endfunction

endpackage

// ----- sv/albm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albm interfaces
// Sample, result and register write channels of the level meter.
// ----------------------------------------------------------------------------
interface albm_in_if;
    import albm_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
    modport source(output valid, sample, last_sample, input ready);
    modport sink(input valid, sample, last_sample, output ready);
endinterface

interface albm_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] peak_level;
    logic        [15:0] rms_level;
    logic signed [11:0] brightness_tenth_db;
    logic        [11:0] sweep_tenth_db;
    logic               saturated;
    modport source(output valid, peak_level, rms_level, brightness_tenth_db,
                   sweep_tenth_db, saturated, input ready);
    modport sink(input valid, peak_level, rms_level, brightness_tenth_db,
                 sweep_tenth_db, saturated, output ready);
endinterface

interface albm_cfg_if;
    import albm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_BITS-1:0]  index;
    logic [DATA_BITS-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/audio_level_brightness_meter.sv -----
`timescale 1ns / 1ps
// A plain sample passes the low-pass, square, accumulate and window-check states before the next accept.
// A qualifying window end adds a log ratio: two log2 passes, then the scale step.
// A last sample adds the run log ratio, a divide, a square root and the emit state.
// A stalled result register holds the block in the emit state.
// No new sample is taken before the last is through: the multiplier and sequencer are shared.
// Reset (synchronous, active low) restores register defaults and clears the run state.
// ----------------------------------------------------------------------------
// audio_level_brightness_meter
// Peak, RMS and spectral tilt meter built around one shared multiplier.
// ----------------------------------------------------------------------------
module audio_level_brightness_meter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    albm_in_if.sink    i_in,
    albm_cfg_if.sink   i_cfg,
    albm_out_if.source o_out
);
    import albm_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LPMUL   = 5'd1;
    localparam logic [4:0] S_LPUPD   = 5'd2;
    localparam logic [4:0] S_HSQ     = 5'd3;
    localparam logic [4:0] S_LSQ     = 5'd4;
    localparam logic [4:0] S_MSQ     = 5'd5;
    localparam logic [4:0] S_ACC     = 5'd6;
    localparam logic [4:0] S_WCHK    = 5'd7;
    localparam logic [4:0] S_LOGLD   = 5'd8;
    localparam logic [4:0] S_LOGNORM = 5'd9;
    localparam logic [4:0] S_LOGMUL  = 5'd10;
    localparam logic [4:0] S_LOGNRM  = 5'd11;
    localparam logic [4:0] S_SCMUL   = 5'd12;
    localparam logic [4:0] S_SCFIN   = 5'd13;
    localparam logic [4:0] S_DIV     = 5'd14;
    localparam logic [4:0] S_SQINIT  = 5'd15;
    localparam logic [4:0] S_SQRT    = 5'd16;
    localparam logic [4:0] S_EMIT    = 5'd17;

    logic [4:0]         r_state;
    logic [15:0]        r_coef, r_wlen;
    logic signed [23:0] r_s8, r_lp;
    logic               r_last;
    logic [15:0]        r_mag, r_peak;
    logic [55:0]        r_sqsum, r_htot, r_ltot;
    logic [47:0]        r_hwin, r_lwin;
    logic [15:0]        r_wpos;
    logic               r_wdone;
    logic [COUNT_BITS-1:0] r_cnt;
    t_db                r_wmin, r_wmax, r_bright;
    logic               r_any, r_sat;
    logic [63:0]        r_prod;
    logic [34:0]        r_he, r_le;
    logic [55:0]        r_lm;
    logic [5:0]         r_exp;
    logic [30:0]        r_mant;
    logic [15:0]        r_frac;
    logic [21:0]        r_lhi;
    logic signed [22:0] r_diff;
    logic               r_lsel, r_run;
    logic [5:0]         r_step;
    logic [55:0]        r_dq;
    logic [24:0]        r_rem;
    logic [55:0]        r_sr, r_sbit;
    logic               r_out_valid;
    logic [15:0]        r_o_peak, r_o_rms;
    t_db                r_o_bright;
    logic [11:0]        r_o_sweep;
    logic               r_o_sat;

    // shared multiplier
    logic [31:0] mul_a, mul_b;

    logic signed [24:0] lp_diff, hp_diff;
    logic [24:0]        lp_dmag, hp_mag, lo_mag;
    logic [25:0]        hq_sum, lq_sum;
    logic [16:0]        hq, lq;
    logic [41:0]        p_sum;
    logic signed [26:0] n_lp27;
    logic signed [23:0] n_lp;
    logic [56:0]        sq_add, ht_add, lt_add;
    logic [48:0]        hw_add, lw_add;
    logic [15:0]        n_wpos;
    logic [55:0]        log_src;
    logic [31:0]        sq_t;
    logic [15:0]        n_frac;
    logic [21:0]        log_val;
    logic [22:0]        d_mag;
    logic [48:0]        sc_sum;
    logic [16:0]        sc_t;
    logic [10:0]        sc_clamp;
    t_db                sc_v;
    logic [COUNT_BITS-1:0] div_d;
    logic [24:0]        div_rs;
    logic               div_ge;
    logic [55:0]        sq_trial;
    logic               emit_ok;

    always_comb begin
        lp_diff = {r_lp[23], r_lp} - {r_s8[23], r_s8};
        lp_dmag = lp_diff[24] ? 25'(-lp_diff) : 25'(lp_diff);
        hp_diff = {r_s8[23], r_s8} - {r_lp[23], r_lp};
        hp_mag  = hp_diff[24] ? 25'(-hp_diff) : 25'(hp_diff);
        lo_mag  = r_lp[23] ? 25'(-{r_lp[23], r_lp}) : {1'b0, r_lp};
        hq_sum  = {1'b0, hp_mag} + 26'd128;
        lq_sum  = {1'b0, lo_mag} + 26'd128;
        hq      = hq_sum[24:8];
        lq      = lq_sum[24:8];
        p_sum   = {1'b0, r_prod[40:0]} + 42'd32768;
        n_lp27  = lp_diff[24] ? 27'({{3{r_s8[23]}}, r_s8}) - 27'({1'b0, p_sum[41:16]})
                              : 27'({{3{r_s8[23]}}, r_s8}) + 27'({1'b0, p_sum[41:16]});
        if (n_lp27 > 27'sd8388607) begin
            n_lp = 24'sh7FFFFF;
        end else if (n_lp27 < -27'sd8388608) begin
            n_lp = 24'sh800000;
        end else begin
            n_lp = n_lp27[23:0];
        end

        sq_add = sat_add56(r_sqsum, {25'd0, r_prod[30:0]});
        ht_add = sat_add56(r_htot, {21'd0, r_he});
        lt_add = sat_add56(r_ltot, {21'd0, r_le});
        hw_add = sat_add48(r_hwin, {13'd0, r_he});
        lw_add = sat_add48(r_lwin, {13'd0, r_le});
        n_wpos = r_wpos + 16'd1;

        if (r_run) begin
            if (r_lsel) log_src = (r_ltot == '0) ? 56'd1 : r_ltot;
            else        log_src = (r_htot == '0) ? 56'd1 : r_htot;
        end else begin
            log_src = r_lsel ? {8'd0, r_lwin} : {8'd0, r_hwin};
        end
        sq_t    = r_prod[61:30];
        n_frac  = {r_frac[14:0], sq_t[31]};
        log_val = {r_exp, n_frac};

        d_mag    = r_diff[22] ? 23'(-r_diff) : 23'(r_diff);
        sc_sum   = {1'b0, r_prod[47:0]} + 49'h0_8000_0000;
        sc_t     = sc_sum[48:32];
        sc_clamp = (sc_t > {6'd0, DB_LIMIT}) ? DB_LIMIT : sc_t[10:0];
        sc_v     = r_diff[22] ? -t_db'({1'b0, sc_clamp}) : t_db'({1'b0, sc_clamp});

        div_d  = (r_cnt == '0) ? COUNT_BITS'(1) : r_cnt;
        div_rs = {r_rem[23:0], r_dq[55]};
        div_ge = div_rs >= {1'b0, div_d};

        sq_trial = r_sr + r_sbit;
        emit_ok  = !r_out_valid || o_out.ready;

        case (r_state)
            S_LPMUL: begin
                mul_a = {7'd0, lp_dmag};
                mul_b = {16'd0, r_coef};
            end
            S_HSQ: begin
                mul_a = {15'd0, hq};
                mul_b = {15'd0, hq};
            end
            S_LSQ: begin
                mul_a = {15'd0, lq};
                mul_b = {15'd0, lq};
            end
            S_MSQ: begin
                mul_a = {16'd0, r_mag};
                mul_b = {16'd0, r_mag};
            end
            S_LOGMUL: begin
                mul_a = {1'b0, r_mant};
                mul_b = {1'b0, r_mant};
            end
            S_SCMUL: begin
                mul_a = {9'd0, d_mag};
                mul_b = DB_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid               = r_out_valid;
    assign o_out.peak_level          = r_o_peak;
    assign o_out.rms_level           = r_o_rms;
    assign o_out.brightness_tenth_db = r_o_bright;
    assign o_out.sweep_tenth_db      = r_o_sweep;
    assign o_out.saturated           = r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_coef      <= SPLIT_COEF_RST;
            r_wlen      <= WIN_LEN_RST;
            r_out_valid <= 1'b0;
            r_lp        <= '0;
            r_peak      <= '0;
            r_sqsum     <= '0;
            r_htot      <= '0;
            r_ltot      <= '0;
            r_hwin      <= '0;
            r_lwin      <= '0;
            r_wpos      <= '0;
            r_cnt       <= '0;
            r_wmin      <= 12'sd2047;
            r_wmax      <= -12'sd2048;
            r_any       <= 1'b0;
            r_sat       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_SPLIT_COEF) r_coef <= i_cfg.data;
                else if (i_cfg.index == REG_WIN_LEN) r_wlen <= i_cfg.data;
            end
            if (r_out_valid && o_out.ready && r_state != S_EMIT) r_out_valid <= 1'b0;

            r_prod <= mul_a * mul_b;

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_s8    <= {i_in.sample, 8'd0};
                        r_mag   <= i_in.sample[15] ? 16'(-{i_in.sample[15], i_in.sample})
                                                   : 16'(i_in.sample);
                        r_last  <= i_in.last_sample;
                        r_state <= S_LPMUL;
                    end
                end
                S_LPMUL: r_state <= S_LPUPD;
                S_LPUPD: begin
                    r_lp    <= n_lp;
                    r_state <= S_HSQ;
                end
                S_HSQ: r_state <= S_LSQ;
                S_LSQ: begin
                    r_he    <= r_prod[34:0];
                    r_state <= S_MSQ;
                end
                S_MSQ: begin
                    r_le    <= r_prod[34:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_mag > r_peak) r_peak <= r_mag;
                    r_sqsum <= sq_add[55:0];
                    r_htot  <= ht_add[55:0];
                    r_ltot  <= lt_add[55:0];
                    r_hwin  <= hw_add[47:0];
                    r_lwin  <= lw_add[47:0];
                    r_cnt   <= (r_cnt == '1) ? r_cnt : r_cnt + COUNT_BITS'(1);
                    if (sq_add[56] || ht_add[56] || lt_add[56] || hw_add[48] ||
                        lw_add[48] || r_cnt == '1) begin
                        r_sat <= 1'b1;
                    end
                    r_wdone <= (n_wpos >= r_wlen);
                    r_wpos  <= (n_wpos >= r_wlen) ? 16'd0 : n_wpos;
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    r_lsel <= 1'b0;
                    if (r_wdone && r_hwin != '0 && r_lwin != '0) begin
                        r_run   <= 1'b0;
                        r_state <= S_LOGLD;
                    end else begin
                        if (r_wdone) begin
                            r_hwin <= '0;
                            r_lwin <= '0;
                        end
                        r_run   <= 1'b1;
                        r_state <= r_last ? S_LOGLD : S_IDLE;
                    end
                end
                S_LOGLD: begin
                    r_lm    <= log_src;
                    r_exp   <= 6'd55;
                    r_state <= S_LOGNORM;
                end
                S_LOGNORM: begin
                    // shift one place a cycle until the leading one reaches the top
                    if (r_lm[55]) begin
                        r_mant  <= r_lm[55:25];
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_state <= S_LOGMUL;
                    end else begin
                        r_lm  <= {r_lm[54:0], 1'b0};
                        r_exp <= r_exp - 6'd1;
                    end
                end
                S_LOGMUL: r_state <= S_LOGNRM;
                S_LOGNRM: begin
                    r_frac <= n_frac;
                    r_mant <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd15) begin
                        if (!r_lsel) begin
                            r_lhi   <= log_val;
                            r_lsel  <= 1'b1;
                            r_state <= S_LOGLD;
                        end else begin
                            r_diff  <= $signed({1'b0, r_lhi}) - $signed({1'b0, log_val});
                            r_state <= S_SCMUL;
                        end
                    end else begin
                        r_state <= S_LOGMUL;
                    end
                end
                S_SCMUL: r_state <= S_SCFIN;
                S_SCFIN: begin
                    r_lsel <= 1'b0;
                    if (r_run) begin
                        r_bright <= sc_v;
                        r_dq     <= r_sqsum;
                        r_rem    <= '0;
                        r_step   <= '0;
                        r_state  <= S_DIV;
                    end else begin
                        if (sc_v < r_wmin) r_wmin <= sc_v;
                        if (sc_v > r_wmax) r_wmax <= sc_v;
                        r_any   <= 1'b1;
                        r_hwin  <= '0;
                        r_lwin  <= '0;
                        r_run   <= 1'b1;
                        r_state <= r_last ? S_LOGLD : S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? div_rs - {1'b0, div_d} : div_rs;
                    r_dq   <= {r_dq[54:0], div_ge};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd55) r_state <= S_SQINIT;
                end
                S_SQINIT: begin
                    r_sr    <= '0;
                    r_sbit  <= 56'd1 << 54;
                    r_step  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_dq >= sq_trial) begin
                        r_dq <= r_dq - sq_trial;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd27) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the result register is free
                    if (emit_ok) begin
                        r_out_valid <= 1'b1;
                        r_o_peak    <= r_peak;
                        r_o_rms     <= r_sr[15:0];
                        r_o_bright  <= r_bright;
                        r_o_sweep   <= r_any ? 12'(r_wmax - r_wmin) : 12'd0;
                        r_o_sat     <= r_sat;
                        r_lp        <= '0;
                        r_peak      <= '0;
                        r_sqsum     <= '0;
                        r_htot      <= '0;
                        r_ltot      <= '0;
                        r_hwin      <= '0;
                        r_lwin      <= '0;
                        r_wpos      <= '0;
                        r_cnt       <= '0;
                        r_wmin      <= 12'sd2047;
                        r_wmax      <= -12'sd2048;
                        r_any       <= 1'b0;
                        r_sat       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/albm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// albm_checker
// Port-level checks on the level meter, bound to the top level.
// ----------------------------------------------------------------------------
module albm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_cfg_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic        [15:0] i_peak,
    input logic        [15:0] i_rms,
    input logic signed [11:0] i_bright,
    input logic        [11:0] i_sweep
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while previous one in flight");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sweep <= 12'd3000) && (i_bright <= 12'sd1500) &&
                        (i_bright >= -12'sd1500))
        else $error("dB result out of range");

    a_rms_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_rms <= i_peak) && (i_peak <= 16'd32768))
        else $error("rms above peak");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register port stalled");

endmodule

bind audio_level_brightness_meter albm_checker u_albm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_peak      (o_out.peak_level),
    .i_rms       (o_out.rms_level),
    .i_bright    (o_out.brightness_tenth_db),
    .i_sweep     (o_out.sweep_tenth_db)
);
